@@ rtl/cts_pkg.sv @@
`default_nettype none

package cts_pkg;

    localparam int CAP_BITS_DEF  = 7;
    localparam int FINE_SPAN_DEF = 7;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        CMD_FULL   = 2'd0,
        CMD_QUICK  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_ABORT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_BUSY      = 3'd1,
        ST_LOCKED    = 3'd2,
        ST_OVERPOWER = 3'd3,
        ST_NORF      = 3'd4,
        ST_SWRHIGH   = 3'd5,
        ST_ABORTED   = 3'd6
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SCAN   = 6'b000010,
        PH_LOCK   = 6'b000100,
        PH_VERIFY = 6'b001000,
        PH_FINE   = 6'b010000,
        PH_QFINAL = 6'b100000
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_WARN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWR_EARLY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWR_LOCK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWR_RECALL = 3'd5;

    localparam logic [CFG_W-1:0] RST_POWER_MAX  = 16'd10000;
    localparam logic [CFG_W-1:0] RST_POWER_MIN  = 16'd100;
    localparam logic [CFG_W-1:0] RST_POWER_WARN = 16'd5000;
    localparam logic [CFG_W-1:0] RST_SWR_EARLY  = 16'd105;
    localparam logic [CFG_W-1:0] RST_SWR_LOCK   = 16'd300;
    localparam logic [CFG_W-1:0] RST_SWR_RECALL = 16'd150;

endpackage

`default_nettype wire

@@ rtl/capacitor_tuning_sequencer.sv @@
`default_nettype none
// Channel   Handshake                  Payload
// request   i_in_valid / o_in_ready    i_cmd, i_fwd_power_mw, i_swr_x100, i_safe_mode,
//                                      i_recall_hit, i_recall_cap, i_recall_swr
// result    o_out_valid / i_out_ready  o_cap_pattern, o_status, o_done_res, o_final_swr,
//                                      o_final_power, o_power_warning, o_save_request
// config    i_cfg_wr_en                i_cfg_addr, i_cfg_wdata
//
// Every request gives one result, written to the result register on acceptance.
// One request per cycle while o_in_ready is high: the sequencer state and the result register update together.
// A waiting result holds o_in_ready low only while i_out_ready is low.
// Synchronous active-low reset: phase idle, relays off, registers to defaults.

module capacitor_tuning_sequencer
    import cts_pkg::*;
#(
    parameter int CAP_BITS  = CAP_BITS_DEF,
    parameter int FINE_SPAN = FINE_SPAN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [15:0]          i_fwd_power_mw,
    input  wire logic [15:0]          i_swr_x100,
    input  wire logic                 i_safe_mode,
    input  wire logic                 i_recall_hit,
    input  wire logic [CAP_BITS-1:0]  i_recall_cap,
    input  wire logic [15:0]          i_recall_swr,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [CAP_BITS-1:0]       o_cap_pattern,
    output logic [2:0]                o_status,
    output logic                      o_done_res,
    output logic [15:0]               o_final_swr,
    output logic [15:0]               o_final_power,
    output logic                      o_power_warning,
    output logic                      o_save_request
);

    localparam int OFF_W = $clog2(2 * FINE_SPAN + 2);
    localparam logic [CAP_BITS-1:0] CAP_MAX = '1;

    logic [CFG_W-1:0] r_power_max, r_power_min, r_power_warn;
    logic [CFG_W-1:0] r_swr_early, r_swr_lock, r_swr_recall;

    t_phase              r_phase, n_phase;
    logic [CAP_BITS-1:0] r_scan, n_scan;
    logic [CAP_BITS-1:0] r_best_cap, n_best_cap;
    logic [15:0]         r_best_swr, n_best_swr;
    logic [OFF_W-1:0]    r_fine_offset, n_fine_offset;
    logic [CAP_BITS-1:0] r_fine_center, n_fine_center;
    logic                r_quick, n_quick;
    logic [CAP_BITS-1:0] r_relay_now, n_relay_now;
    logic [15:0]         r_start_power, n_start_power;
    logic                r_warn, n_warn;

    logic                r_out_valid;
    logic [CAP_BITS-1:0] r_out_cap;
    t_status             r_out_status;
    logic                r_out_done;
    logic [15:0]         r_out_swr;
    logic [15:0]         r_out_pwr;
    logic                r_out_warn;
    logic                r_out_save;

    t_status     res_status;
    logic        res_done;
    logic [15:0] res_swr;
    logic [15:0] res_pwr;
    logic        res_warn;
    logic        res_save;

    logic                accept;
    logic [OFF_W-1:0]    seek_start;
    logic                seek_found;
    logic [OFF_W-1:0]    seek_offset;
    logic [CAP_BITS-1:0] seek_cap;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign seek_start = (r_phase == PH_VERIFY) ? '0 : r_fine_offset + OFF_W'(1);

    cts_fine_seek #(
        .CAP_BITS  (CAP_BITS),
        .FINE_SPAN (FINE_SPAN)
    ) u_seek (
        .i_center (r_fine_center),
        .i_start  (seek_start),
        .o_found  (seek_found),
        .o_offset (seek_offset),
        .o_cap    (seek_cap)
    );

    always_comb begin
        logic do_full;
        logic full_quick;
        logic better;
        n_phase       = r_phase;
        n_scan        = r_scan;
        n_best_cap    = r_best_cap;
        n_best_swr    = r_best_swr;
        n_fine_offset = r_fine_offset;
        n_fine_center = r_fine_center;
        n_quick       = r_quick;
        n_relay_now   = r_relay_now;
        n_start_power = r_start_power;
        n_warn        = r_warn;
        res_status    = ST_BUSY;
        res_done      = 1'b0;
        res_swr       = '0;
        res_pwr       = '0;
        res_warn      = r_warn;
        res_save      = 1'b0;
        do_full       = 1'b0;
        full_quick    = 1'b0;
        better        = i_swr_x100 < r_best_swr;

        if (i_cmd == CMD_ABORT) begin
            n_relay_now = '0;
            n_warn      = 1'b0;
            n_phase     = PH_IDLE;
            res_status  = ST_ABORTED;
            res_done    = 1'b1;
            res_warn    = 1'b0;
        end else if (r_phase == PH_IDLE) begin
            if (i_cmd == CMD_FULL) begin
                do_full = 1'b1;
            end else if (i_cmd == CMD_QUICK) begin
                if (i_fwd_power_mw > r_power_max) begin
                    n_relay_now = '0;
                    n_warn      = 1'b0;
                    res_status  = ST_OVERPOWER;
                    res_done    = 1'b1;
                    res_pwr     = i_fwd_power_mw;
                    res_warn    = 1'b0;
                end else if (i_recall_hit && (i_recall_swr < r_swr_recall)) begin
                    n_quick       = 1'b1;
                    n_warn        = 1'b0;
                    n_start_power = i_fwd_power_mw;
                    n_fine_center = i_recall_cap;
                    n_relay_now   = i_recall_cap;
                    n_phase       = PH_VERIFY;
                    res_warn      = 1'b0;
                end else begin
                    do_full    = 1'b1;
                    full_quick = 1'b1;
                end
            end else begin
                res_status = ST_IDLE;
                res_warn   = 1'b0;
            end
        end else if (i_cmd == CMD_SAMPLE) begin
            case (r_phase)
                PH_SCAN: begin
                    if (i_fwd_power_mw > r_power_max) begin
                        n_relay_now = '0;
                        n_phase     = PH_IDLE;
                        n_warn      = 1'b0;
                        res_status  = ST_OVERPOWER;
                        res_done    = 1'b1;
                        res_pwr     = i_fwd_power_mw;
                    end else if (i_fwd_power_mw < r_power_min) begin
                        n_relay_now = '0;
                        n_phase     = PH_IDLE;
                        n_warn      = 1'b0;
                        res_status  = ST_NORF;
                        res_done    = 1'b1;
                        res_pwr     = i_fwd_power_mw;
                    end else begin
                        if (better) begin
                            n_best_swr = i_swr_x100;
                            n_best_cap = r_scan;
                        end
                        if (better && (i_swr_x100 < r_swr_early)) begin
                            n_relay_now = r_scan;
                            n_phase     = PH_LOCK;
                        end else if (r_scan == CAP_MAX) begin
                            n_relay_now = better ? r_scan : r_best_cap;
                            n_phase     = PH_LOCK;
                        end else begin
                            n_scan      = r_scan + CAP_BITS'(1);
                            n_relay_now = r_scan + CAP_BITS'(1);
                        end
                    end
                end
                PH_LOCK: begin
                    n_phase  = PH_IDLE;
                    n_warn   = 1'b0;
                    res_done = 1'b1;
                    res_swr  = i_swr_x100;
                    res_pwr  = i_fwd_power_mw;
                    if (i_swr_x100 < r_swr_lock) begin
                        res_status = ST_LOCKED;
                        res_save   = r_quick;
                    end else begin
                        res_status = ST_SWRHIGH;
                    end
                end
                PH_VERIFY: begin
                    if (i_swr_x100 < r_swr_recall) begin
                        n_best_cap = r_fine_center;
                        n_best_swr = i_swr_x100;
                        if (seek_found) begin
                            n_fine_offset = seek_offset;
                            n_relay_now   = seek_cap;
                            n_phase       = PH_FINE;
                        end else begin
                            n_relay_now = r_fine_center;
                            n_phase     = PH_QFINAL;
                        end
                    end else begin
                        do_full    = 1'b1;
                        full_quick = 1'b1;
                    end
                end
                PH_FINE: begin
                    if (i_fwd_power_mw > r_power_max) begin
                        n_relay_now = r_best_cap;
                        n_phase     = PH_QFINAL;
                    end else begin
                        if (better) begin
                            n_best_swr = i_swr_x100;
                            n_best_cap = r_relay_now;
                        end
                        if (better && (i_swr_x100 < r_swr_early)) begin
                            n_phase = PH_QFINAL;
                        end else if (seek_found) begin
                            n_fine_offset = seek_offset;
                            n_relay_now   = seek_cap;
                        end else begin
                            n_relay_now = better ? r_relay_now : r_best_cap;
                            n_phase     = PH_QFINAL;
                        end
                    end
                end
                PH_QFINAL: begin
                    n_phase  = PH_IDLE;
                    n_warn   = 1'b0;
                    res_done = 1'b1;
                    res_swr  = i_swr_x100;
                    res_pwr  = r_start_power;
                    if (i_swr_x100 < r_swr_lock) begin
                        res_status = ST_LOCKED;
                        res_save   = 1'b1;
                    end else begin
                        res_status = ST_SWRHIGH;
                    end
                end
                default: begin
                    n_relay_now = '0;
                    n_phase     = PH_IDLE;
                    n_warn      = 1'b0;
                    res_status  = ST_ABORTED;
                    res_done    = 1'b1;
                end
            endcase
        end

        if (do_full) begin
            n_quick  = full_quick;
            n_warn   = 1'b0;
            res_warn = 1'b0;
            if (i_safe_mode) begin
                n_phase    = PH_IDLE;
                res_status = ST_SWRHIGH;
                res_done   = 1'b1;
            end else if (i_fwd_power_mw > r_power_max) begin
                n_relay_now = '0;
                n_phase     = PH_IDLE;
                res_status  = ST_OVERPOWER;
                res_done    = 1'b1;
                res_pwr     = i_fwd_power_mw;
            end else if (i_fwd_power_mw < r_power_min) begin
                n_phase    = PH_IDLE;
                res_status = ST_NORF;
                res_done   = 1'b1;
                res_pwr    = i_fwd_power_mw;
            end else begin
                n_warn        = i_fwd_power_mw > r_power_warn;
                res_warn      = i_fwd_power_mw > r_power_warn;
                n_start_power = i_fwd_power_mw;
                n_best_cap    = '0;
                n_best_swr    = '1;
                n_scan        = '0;
                n_relay_now   = '0;
                n_phase       = PH_SCAN;
                res_status    = ST_BUSY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_max  <= RST_POWER_MAX;
            r_power_min  <= RST_POWER_MIN;
            r_power_warn <= RST_POWER_WARN;
            r_swr_early  <= RST_SWR_EARLY;
            r_swr_lock   <= RST_SWR_LOCK;
            r_swr_recall <= RST_SWR_RECALL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_POWER_MAX:  r_power_max  <= i_cfg_wdata;
                CFG_POWER_MIN:  r_power_min  <= i_cfg_wdata;
                CFG_POWER_WARN: r_power_warn <= i_cfg_wdata;
                CFG_SWR_EARLY:  r_swr_early  <= i_cfg_wdata;
                CFG_SWR_LOCK:   r_swr_lock   <= i_cfg_wdata;
                CFG_SWR_RECALL: r_swr_recall <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_scan        <= '0;
            r_best_cap    <= '0;
            r_best_swr    <= '1;
            r_fine_offset <= '0;
            r_fine_center <= '0;
            r_quick       <= 1'b0;
            r_relay_now   <= '0;
            r_start_power <= '0;
            r_warn        <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_scan        <= n_scan;
            r_best_cap    <= n_best_cap;
            r_best_swr    <= n_best_swr;
            r_fine_offset <= n_fine_offset;
            r_fine_center <= n_fine_center;
            r_quick       <= n_quick;
            r_relay_now   <= n_relay_now;
            r_start_power <= n_start_power;
            r_warn        <= n_warn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_cap    <= n_relay_now;
            r_out_status <= res_status;
            r_out_done   <= res_done;
            r_out_swr    <= res_swr;
            r_out_pwr    <= res_pwr;
            r_out_warn   <= res_warn;
            r_out_save   <= res_save;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cap_pattern   = r_out_cap;
    assign o_status        = r_out_status;
    assign o_done_res      = r_out_done;
    assign o_final_swr     = r_out_swr;
    assign o_final_power   = r_out_pwr;
    assign o_power_warning = r_out_warn;
    assign o_save_request  = r_out_save;

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && res_done |=> r_phase == PH_IDLE)
        else $error("finished run left sequencer active");

    a_relay_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_cap_pattern == r_relay_now)
        else $error("reported pattern differs from applied relays");

    a_fine_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_FINE |-> r_fine_offset <= OFF_W'(2 * FINE_SPAN))
        else $error("fine offset outside window");

endmodule

`default_nettype wire

@@ rtl/cts_fine_seek.sv @@
`default_nettype none

module cts_fine_seek
    import cts_pkg::*;
#(
    parameter int CAP_BITS  = CAP_BITS_DEF,
    parameter int FINE_SPAN = FINE_SPAN_DEF,
    localparam int OFF_W    = $clog2(2 * FINE_SPAN + 2)
) (
    input  wire logic [CAP_BITS-1:0] i_center,
    input  wire logic [OFF_W-1:0]    i_start,
    output logic                     o_found,
    output logic [OFF_W-1:0]         o_offset,
    output logic [CAP_BITS-1:0]      o_cap
);

    localparam int NCAND = 2 * FINE_SPAN + 1;
    localparam int SW    = $clog2((1 << CAP_BITS) + 2 * FINE_SPAN) + 1;
    localparam logic signed [SW-1:0] CMAX = SW'((1 << CAP_BITS) - 1);

    logic [NCAND-1:0]    usable;
    logic [CAP_BITS-1:0] cand [NCAND];

    always_comb begin
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] ctr;
        ctr = $signed(SW'(i_center));
        for (int k = 0; k < NCAND; k++) begin
            c = ctr + $signed(SW'(k)) - $signed(SW'(FINE_SPAN));
            if (c < 0) begin
                c = '0;
            end
            if (c > CMAX) begin
                c = CMAX;
            end
            cand[k]   = c[CAP_BITS-1:0];
            usable[k] = (OFF_W'(k) >= i_start) && !((c == ctr) && (k != FINE_SPAN));
        end
    end

    always_comb begin
        o_found  = 1'b0;
        o_offset = '0;
        o_cap    = '0;
        for (int k = NCAND - 1; k >= 0; k--) begin
            if (usable[k]) begin
                o_found  = 1'b1;
                o_offset = OFF_W'(k);
                o_cap    = cand[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/capacitor_tuning_sequencer_tb.sv @@
`default_nettype none

module capacitor_tuning_sequencer_tb;
    import cts_pkg::*;

    localparam int CAP_MAX   = 127;
    localparam int SPAN      = 7;
    localparam int HOLD_LEN  = 100;
    localparam int WDOG_MAX  = 3000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] pwr;
        logic [15:0] swr;
        logic        safe;
        logic        hit;
        logic [6:0]  rcap;
        logic [15:0] rswr;
    } t_tune_req;

    typedef struct packed {
        logic [6:0]  cap;
        logic [2:0]  status;
        logic        done;
        logic [15:0] fswr;
        logic [15:0] fpwr;
        logic        warn;
        logic        save;
    } t_tune_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 out_ready = 1'b0;
    t_tune_req            drv_req = '0;

    wire logic            o_in_ready;
    wire logic            o_out_valid;
    wire logic [6:0]      o_cap_pattern;
    wire logic [2:0]      o_status;
    wire logic            o_done_res;
    wire logic [15:0]     o_final_swr;
    wire logic [15:0]     o_final_power;
    wire logic            o_power_warning;
    wire logic            o_save_request;

    capacitor_tuning_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (drv_req.cmd),
        .i_fwd_power_mw  (drv_req.pwr),
        .i_swr_x100      (drv_req.swr),
        .i_safe_mode     (drv_req.safe),
        .i_recall_hit    (drv_req.hit),
        .i_recall_cap    (drv_req.rcap),
        .i_recall_swr    (drv_req.rswr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_cap_pattern   (o_cap_pattern),
        .o_status        (o_status),
        .o_done_res      (o_done_res),
        .o_final_swr     (o_final_swr),
        .o_final_power   (o_final_power),
        .o_power_warning (o_power_warning),
        .o_save_request  (o_save_request)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sequencer copy: registers
    logic [15:0] pwr_max    = RST_POWER_MAX;
    logic [15:0] pwr_min    = RST_POWER_MIN;
    logic [15:0] pwr_warn   = RST_POWER_WARN;
    logic [15:0] swr_early  = RST_SWR_EARLY;
    logic [15:0] swr_lock   = RST_SWR_LOCK;
    logic [15:0] swr_recall = RST_SWR_RECALL;

    // sequencer copy: state
    t_phase      seq_ph    = PH_IDLE;
    logic [6:0]  scan_idx  = '0;
    logic [6:0]  best_cap  = '0;
    logic [15:0] best_swr  = '1;
    logic [4:0]  fine_off  = '0;
    logic [6:0]  fine_ctr  = '0;
    logic        quick     = 1'b0;
    logic [6:0]  relay     = '0;
    logic [15:0] start_pwr = '0;
    logic        warn      = 1'b0;

    t_tune_req pending_reqs[$];
    t_tune_res predicted_res[$];

    int send_idle_pct = 12;
    int recv_idle_pct = 70;
    int n_built = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_locked = 0;
    int n_saves = 0;
    int n_cfg = 0;
    int n_errors = 0;

    function automatic t_tune_res make_res(logic [2:0] st, logic dn, logic [15:0] fs,
                                           logic [15:0] fp, logic w, logic sv);
        t_tune_res r;
        r = '{relay, st, dn, fs, fp, w, sv};
        return r;
    endfunction

    function automatic t_tune_res end_run(logic [2:0] st, logic [15:0] fs, logic [15:0] fp,
                                          logic sv);
        logic w;
        w = warn;
        seq_ph = PH_IDLE;
        warn = 1'b0;
        return make_res(st, 1'b1, fs, fp, w, sv);
    endfunction

    function automatic bit fine_seek(int k);
        int c;
        for (int j = k; j <= 2 * SPAN; j++) begin
            c = int'(fine_ctr) + j - SPAN;
            if (c < 0) c = 0;
            if (c > CAP_MAX) c = CAP_MAX;
            if (!(c == int'(fine_ctr) && j != SPAN)) begin
                fine_off = j[4:0];
                relay = c[6:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_tune_res start_sweep(t_tune_req r, logic q);
        quick = q;
        warn = 1'b0;
        if (r.safe) return end_run(ST_SWRHIGH, 16'd0, 16'd0, 1'b0);
        if (r.pwr > pwr_max) begin
            relay = '0;
            return end_run(ST_OVERPOWER, 16'd0, r.pwr, 1'b0);
        end
        if (r.pwr < pwr_min) return end_run(ST_NORF, 16'd0, r.pwr, 1'b0);
        warn = (r.pwr > pwr_warn);
        start_pwr = r.pwr;
        best_cap = '0;
        best_swr = '1;
        scan_idx = '0;
        relay = '0;
        seq_ph = PH_SCAN;
        return make_res(ST_BUSY, 1'b0, 16'd0, 16'd0, warn, 1'b0);
    endfunction

    function automatic t_tune_res predict_tuning(t_tune_req r);
        bit lock_now;
        bit fine_end;
        if (r.cmd == CMD_ABORT) begin
            relay = '0;
            warn = 1'b0;
            seq_ph = PH_IDLE;
            return make_res(ST_ABORTED, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        end
        if (seq_ph == PH_IDLE) begin
            if (r.cmd == CMD_FULL) return start_sweep(r, 1'b0);
            if (r.cmd == CMD_QUICK) begin
                if (r.pwr > pwr_max) begin
                    relay = '0;
                    warn = 1'b0;
                    return end_run(ST_OVERPOWER, 16'd0, r.pwr, 1'b0);
                end
                if (r.hit && r.rswr < swr_recall) begin
                    quick = 1'b1;
                    warn = 1'b0;
                    start_pwr = r.pwr;
                    fine_ctr = r.rcap;
                    relay = r.rcap;
                    seq_ph = PH_VERIFY;
                    return make_res(ST_BUSY, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
                end
                return start_sweep(r, 1'b1);
            end
            return make_res(ST_IDLE, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        end
        if (r.cmd != CMD_SAMPLE)
            return make_res(ST_BUSY, 1'b0, 16'd0, 16'd0, warn, 1'b0);

        case (seq_ph)
            PH_SCAN: begin
                if (r.pwr > pwr_max) begin
                    relay = '0;
                    return end_run(ST_OVERPOWER, 16'd0, r.pwr, 1'b0);
                end
                if (r.pwr < pwr_min) begin
                    relay = '0;
                    return end_run(ST_NORF, 16'd0, r.pwr, 1'b0);
                end
                lock_now = 1'b0;
                if (r.swr < best_swr) begin
                    best_swr = r.swr;
                    best_cap = scan_idx;
                    lock_now = (r.swr < swr_early);
                end
                if (lock_now || scan_idx == CAP_MAX) begin
                    relay = best_cap;
                    seq_ph = PH_LOCK;
                end else begin
                    scan_idx = scan_idx + 7'd1;
                    relay = scan_idx;
                end
            end
            PH_LOCK: begin
                if (r.swr < swr_lock) return end_run(ST_LOCKED, r.swr, r.pwr, quick);
                return end_run(ST_SWRHIGH, r.swr, r.pwr, 1'b0);
            end
            PH_VERIFY: begin
                if (r.swr >= swr_recall) return start_sweep(r, 1'b1);
                best_cap = fine_ctr;
                best_swr = r.swr;
                seq_ph = PH_FINE;
                if (!fine_seek(0)) begin
                    relay = best_cap;
                    seq_ph = PH_QFINAL;
                end
            end
            PH_FINE: begin
                fine_end = 1'b0;
                if (r.pwr > pwr_max) begin
                    fine_end = 1'b1;
                end else begin
                    if (r.swr < best_swr) begin
                        best_swr = r.swr;
                        best_cap = relay;
                        fine_end = (r.swr < swr_early);
                    end
                    if (!fine_end) fine_end = !fine_seek(int'(fine_off) + 1);
                end
                if (fine_end) begin
                    relay = best_cap;
                    seq_ph = PH_QFINAL;
                end
            end
            PH_QFINAL: begin
                if (r.swr < swr_lock) return end_run(ST_LOCKED, r.swr, start_pwr, 1'b1);
                return end_run(ST_SWRHIGH, r.swr, start_pwr, 1'b0);
            end
            default: begin
                relay = '0;
                return end_run(ST_ABORTED, 16'd0, 16'd0, 1'b0);
            end
        endcase
        return make_res(ST_BUSY, 1'b0, 16'd0, 16'd0, warn, 1'b0);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predicted_res.push_back(predict_tuning(drv_req));
                n_accepted++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_req <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result monitor
    int  hold_left = 0;
    bit  held = 1'b0;
    t_tune_res want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_results++;
                if (predicted_res.size() == 0) begin
                    n_errors++;
                    $display("%0t: result with nothing expected: status %0d", $time, o_status);
                end else begin
                    want = predicted_res.pop_front();
                    check_field("cap_pattern", want.cap, o_cap_pattern);
                    check_field("status", want.status, o_status);
                    check_field("done_res", want.done, o_done_res);
                    check_field("final_swr", want.fswr, o_final_swr);
                    check_field("final_power", want.fpwr, o_final_power);
                    check_field("power_warning", want.warn, o_power_warning);
                    check_field("save_request", want.save, o_save_request);
                    if (want.status == ST_LOCKED) n_locked++;
                    if (want.save) n_saves++;
                end
            end
            if (!held && n_results == 60) begin
                hold_left = HOLD_LEN;
                held = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    int wdog = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, WDOG_MAX);
                $display("capacitor_tuning_sequencer_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic void add_req(t_tune_req r);
        pending_reqs.push_back(r);
        n_built++;
    endfunction

    function automatic t_tune_req mk_req(logic [1:0] cmd, logic [15:0] pwr, logic [15:0] swr,
                                         logic safe, logic hit, logic [6:0] rcap,
                                         logic [15:0] rswr);
        t_tune_req r;
        r = '{cmd, pwr, swr, safe, hit, rcap, rswr};
        return r;
    endfunction

    function automatic t_tune_req noise_req();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_tune_req)-1:0];
    endfunction

    function automatic logic [15:0] in_window_pwr();
        if (pwr_min <= pwr_max) return 16'($urandom_range(pwr_max, pwr_min));
        return 16'($urandom);
    endfunction

    function automatic void add_session(bit allow_long);
        t_tune_req r;
        int n;
        bit long_sweep;
        r = noise_req();
        r.pwr = ($urandom_range(9) == 0) ? 16'($urandom) : in_window_pwr();
        r.safe = ($urandom_range(19) == 0);
        if ($urandom_range(1) == 0) begin
            r.cmd = CMD_FULL;
        end else begin
            r.cmd = CMD_QUICK;
            r.hit = ($urandom_range(4) != 0);
            r.rswr = ($urandom_range(3) != 0) ? 16'($urandom_range(200)) : 16'($urandom);
        end
        add_req(r);
        long_sweep = allow_long && ($urandom_range(14) == 0);
        n = long_sweep ? 135 : int'($urandom_range(24, 2));
        for (int i = 0; i < n; i++) begin
            r = noise_req();
            case ($urandom_range(39))
                0: ;
                1: r.cmd = CMD_ABORT;
                default: begin
                    r.cmd = CMD_SAMPLE;
                    if ($urandom_range(12) != 0) r.pwr = in_window_pwr();
                    if (long_sweep)
                        r.swr = 16'($urandom_range(65535, swr_early));
                    else
                        case ($urandom_range(9))
                            0: ;
                            1, 2, 3: r.swr = 16'($urandom_range(160));
                            default: r.swr = 16'($urandom_range(2000, 80));
                        endcase
                end
            endcase
            add_req(r);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_POWER_MAX:  pwr_max = val;
            CFG_POWER_MIN:  pwr_min = val;
            CFG_POWER_WARN: pwr_warn = val;
            CFG_SWR_EARLY:  swr_early = val;
            CFG_SWR_LOCK:   swr_lock = val;
            CFG_SWR_RECALL: swr_recall = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic write_all(logic [15:0] pmax, logic [15:0] pmin, logic [15:0] pwarn,
                             logic [15:0] early, logic [15:0] lock, logic [15:0] recall);
        write_reg(CFG_POWER_MAX, pmax);
        write_reg(CFG_POWER_MIN, pmin);
        write_reg(CFG_POWER_WARN, pwarn);
        write_reg(CFG_SWR_EARLY, early);
        write_reg(CFG_SWR_LOCK, lock);
        write_reg(CFG_SWR_RECALL, recall);
    endtask

    task automatic run_random(int count, bit allow_long);
        int goal;
        goal = n_built + count;
        while (n_built < goal) add_session(allow_long);
        add_req(mk_req(CMD_ABORT, 16'd0, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        while (pending_reqs.size() != 0 || in_valid || predicted_res.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass at reset thresholds
        add_req(mk_req(CMD_SAMPLE, 16'd500, 16'd50, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_FULL, 16'd1000, 16'd0, 1'b1, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_FULL, 16'hFFFF, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_FULL, 16'd0, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd20000, 16'd0, 1'b0, 1'b1, 7'd5, 16'd10));
        add_req(mk_req(CMD_FULL, 16'd6000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd1000, 16'd0, 1'b0, 1'b1, 7'd3, 16'd10));
        add_req(mk_req(CMD_SAMPLE, 16'd200, 16'hFFFF, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd200, 16'd50, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd200, 16'd299, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd800, 16'd0, 1'b0, 1'b1, 7'd0, 16'd10));
        add_req(mk_req(CMD_SAMPLE, 16'd800, 16'd100, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'hFFFF, 16'd90, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd800, 16'd500, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd700, 16'd0, 1'b0, 1'b1, 7'd127, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd1000, 16'd200, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd50, 16'd200, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_FULL, 16'd1000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd20000, 16'd200, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd1000, 16'd0, 1'b0, 1'b0, 7'd9, 16'd10));
        add_req(mk_req(CMD_ABORT, 16'd1000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_QUICK, 16'd3000, 16'd0, 1'b0, 1'b1, 7'd64, 16'd149));
        add_req(mk_req(CMD_SAMPLE, 16'd3000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd3000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        add_req(mk_req(CMD_SAMPLE, 16'd3000, 16'd0, 1'b0, 1'b0, 7'd0, 16'd0));
        run_random(130, 1'b1);

        write_all(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_idle_pct = 70;
        recv_idle_pct = 12;
        run_random(130, 1'b1);

        write_all(16'($urandom_range(65535, 2000)), 16'($urandom_range(1000)),
                  16'($urandom), 16'($urandom_range(400, 50)),
                  16'($urandom_range(1000, 100)), 16'($urandom_range(400, 100)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(130, 1'b1);

        write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        run_random(40, 1'b0);

        if (predicted_res.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, predicted_res.size());
        end
        $display("covered %0d requests, %0d results (%0d locked, %0d save requests)",
                 n_accepted, n_results, n_locked, n_saves);
        $display("%0d register writes over four threshold sets, %0d mismatches",
                 n_cfg, n_errors);
        if (n_errors == 0)
            $display("capacitor_tuning_sequencer_tb: done, clean");
        else
            $display("capacitor_tuning_sequencer_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/cts_pkg.sv
rtl/cts_fine_seek.sv
rtl/capacitor_tuning_sequencer.sv
bench/capacitor_tuning_sequencer_tb.sv
